// ===== rtl/nst_pkg.sv =====
`timescale 1ns / 1ps

package nst_pkg;

  localparam logic [1:0] ST_WAIT   = 2'd0;
  localparam logic [1:0] ST_ATTACK = 2'd1;
  localparam logic [1:0] ST_MON    = 2'd2;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_SCALE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REQUIRED_DECLINES   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RESET_FRACTION      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REARM_LOW_FRACTION  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REARM_HIGH_FRACTION = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE         = 3'd5;

  localparam int CFG_DATA_W = 20;

  localparam logic [9:0]  RST_THRESHOLD_SCALE     = 10'd128;
  localparam logic [3:0]  RST_REQUIRED_DECLINES   = 4'd3;
  localparam logic [7:0]  RST_RESET_FRACTION      = 8'd74;
  localparam logic [7:0]  RST_REARM_LOW_FRACTION  = 8'd154;
  localparam logic [7:0]  RST_REARM_HIGH_FRACTION = 8'd192;
  localparam logic [19:0] RST_SAMPLE_RATE         = 20'd48000;

  localparam logic [47:0] SAMPLE_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [3:0]  STREAK_MAX = 4'd15;

  typedef struct packed {
    logic [15:0] raw_peak;
    logic [15:0] envelope_max;
    logic [17:0] peak_hz;
    logic [15:0] frame_size;
  } frame_t;

  typedef struct packed {
    logic [1:0]  tracker_state;
    logic [1:0]  previous_state;
    logic [17:0] captured_hz;
    logic        retrigger_seen;
    logic        retrigger_ready;
    logic [47:0] strike_start_count;
    logic [47:0] samples_seen;
    logic [3:0]  decline_count;
  } result_t;

  typedef struct packed {
    logic [9:0]  threshold_scale;
    logic [3:0]  required_declines;
    logic [7:0]  reset_fraction;
    logic [7:0]  rearm_low_fraction;
    logic [7:0]  rearm_high_fraction;
    logic [19:0] sample_rate;
  } cfg_t;

endpackage

// ===== rtl/nst_frame_if.sv =====
`timescale 1ns / 1ps

interface nst_frame_if;
  logic            valid;
  logic            ready;
  nst_pkg::frame_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/nst_result_if.sv =====
`timescale 1ns / 1ps

interface nst_result_if;
  logic             valid;
  logic             ready;
  nst_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/nst_cfg_if.sv =====
`timescale 1ns / 1ps

interface nst_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [nst_pkg::CFG_INDEX_W-1:0]    index;
  logic [nst_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/nst_cfg_regs.sv =====
`timescale 1ns / 1ps

module nst_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  nst_cfg_if.sink        cfg,
  output nst_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.threshold_scale     <= nst_pkg::RST_THRESHOLD_SCALE;
      regs.required_declines   <= nst_pkg::RST_REQUIRED_DECLINES;
      regs.reset_fraction      <= nst_pkg::RST_RESET_FRACTION;
      regs.rearm_low_fraction  <= nst_pkg::RST_REARM_LOW_FRACTION;
      regs.rearm_high_fraction <= nst_pkg::RST_REARM_HIGH_FRACTION;
      regs.sample_rate         <= nst_pkg::RST_SAMPLE_RATE;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        nst_pkg::REG_THRESHOLD_SCALE:     regs.threshold_scale     <= cfg.data[9:0];
        nst_pkg::REG_REQUIRED_DECLINES:   regs.required_declines   <= cfg.data[3:0];
        nst_pkg::REG_RESET_FRACTION:      regs.reset_fraction      <= cfg.data[7:0];
        nst_pkg::REG_REARM_LOW_FRACTION:  regs.rearm_low_fraction  <= cfg.data[7:0];
        nst_pkg::REG_REARM_HIGH_FRACTION: regs.rearm_high_fraction <= cfg.data[7:0];
        nst_pkg::REG_SAMPLE_RATE:         regs.sample_rate         <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/nst_tracker.sv =====
`timescale 1ns / 1ps

module nst_tracker (
  input  logic              clk,
  input  logic              rst,
  input  nst_pkg::cfg_t     regs,
  input  logic              fire,
  input  nst_pkg::frame_t   item,
  output nst_pkg::result_t  res
);

  logic [1:0]  mode, prior_mode;
  logic [15:0] last_peak, cluster_level;
  logic [3:0]  streak;
  logic [17:0] held_freq;
  logic        rearmed, retriggered;
  logic [47:0] sample_total, start_total;

  logic [1:0]  mode_next, prior_mode_next;
  logic [15:0] last_peak_next, cluster_level_next;
  logic [3:0]  streak_next, streak_inc;
  logic [17:0] held_freq_next;
  logic        rearmed_next, retriggered_next;
  logic [47:0] sample_total_next, start_total_next;

  logic [48:0] sum;
  logic [23:0] p256;
  logic [25:0] thr;
  logic [18:0] p5;
  logic [23:0] c_reset, c_low, c_high;
  logic        trigger, fallback, below_reset, below_low, above_high;

  assign p256    = {item.raw_peak, 8'd0};
  assign thr     = regs.threshold_scale * item.envelope_max;
  assign p5      = {3'b000, item.raw_peak} + {1'b0, item.raw_peak, 2'b00};
  assign c_reset = cluster_level * regs.reset_fraction;
  assign c_low   = cluster_level * regs.rearm_low_fraction;
  assign c_high  = cluster_level * regs.rearm_high_fraction;

  assign trigger     = {2'b00, p256} > thr;
  // 0.8 test as 5*256*peak < 4*thr
  assign fallback    = {1'b0, p5, 8'd0} < {thr, 2'b00};
  assign below_reset = p256 < c_reset;
  assign below_low   = p256 < c_low;
  assign above_high  = p256 > c_high;

  assign sum        = {1'b0, sample_total} + {33'd0, item.frame_size};
  assign streak_inc = (streak == nst_pkg::STREAK_MAX) ? streak : streak + 4'd1;

  always_comb begin
    mode_next          = mode;
    prior_mode_next    = prior_mode;
    last_peak_next     = last_peak;
    cluster_level_next = cluster_level;
    streak_next        = streak;
    held_freq_next     = held_freq;
    rearmed_next       = rearmed;
    retriggered_next   = retriggered;
    sample_total_next  = sample_total;
    start_total_next   = start_total;
    if (regs.sample_rate != '0) begin
      sample_total_next = sum[48] ? nst_pkg::SAMPLE_MAX : sum[47:0];
      last_peak_next    = item.raw_peak;
      prior_mode_next   = mode;
      unique case (mode)
        nst_pkg::ST_ATTACK: begin
          if (item.raw_peak < last_peak) begin
            streak_next = streak_inc;
            if (streak_inc >= regs.required_declines) begin
              mode_next          = nst_pkg::ST_MON;
              cluster_level_next = item.raw_peak;
              held_freq_next     = item.peak_hz;
              rearmed_next       = 1'b0;
            end
          end else begin
            streak_next = '0;
          end
          // fallback overrides a move to monitoring in the same frame
          if (fallback) begin
            mode_next    = nst_pkg::ST_WAIT;
            streak_next  = '0;
            rearmed_next = 1'b0;
          end
        end
        nst_pkg::ST_MON: begin
          if (below_reset) begin
            mode_next    = nst_pkg::ST_WAIT;
            streak_next  = '0;
            rearmed_next = 1'b0;
          end else if (below_low) begin
            rearmed_next = 1'b1;
          end else if (rearmed && above_high) begin
            retriggered_next = 1'b1;
            held_freq_next   = item.peak_hz;
            rearmed_next     = 1'b0;
          end
        end
        default: begin
          // unused code behaves as waiting
          mode_next = nst_pkg::ST_WAIT;
          if (trigger) begin
            mode_next        = nst_pkg::ST_ATTACK;
            start_total_next = sample_total_next;
            streak_next      = '0;
            retriggered_next = 1'b0;
            rearmed_next     = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= nst_pkg::ST_WAIT;
      prior_mode    <= nst_pkg::ST_WAIT;
      last_peak     <= '0;
      cluster_level <= '0;
      streak        <= '0;
      held_freq     <= '0;
      rearmed       <= 1'b0;
      retriggered   <= 1'b0;
      sample_total  <= '0;
      start_total   <= '0;
    end else if (fire) begin
      mode          <= mode_next;
      prior_mode    <= prior_mode_next;
      last_peak     <= last_peak_next;
      cluster_level <= cluster_level_next;
      streak        <= streak_next;
      held_freq     <= held_freq_next;
      rearmed       <= rearmed_next;
      retriggered   <= retriggered_next;
      sample_total  <= sample_total_next;
      start_total   <= start_total_next;
    end
  end

  assign res.tracker_state      = mode_next;
  assign res.previous_state     = prior_mode_next;
  assign res.captured_hz        = held_freq_next;
  assign res.retrigger_seen     = retriggered_next;
  assign res.retrigger_ready    = rearmed_next;
  assign res.strike_start_count = start_total_next;
  assign res.samples_seen       = sample_total_next;
  assign res.decline_count      = streak_next;

endmodule

// ===== rtl/note_strike_tracker.sv =====
`timescale 1ns / 1ps

// Note strike tracker: takes one analysis frame per transaction and returns
// one result per frame, in order. A frame is taken every cycle when the
// result side keeps up; a frame passes through the frame register, then the result
// register, and the tracker state is updated as a frame moves from the
// frame register into the result register, so the next frame sees it at
// once. Writes on the configuration channel are taken every cycle and must
// only be issued while no frame is in flight. strike_start_count is a sample
// count; divide by sample_rate for seconds. A sample_rate of zero turns each
// frame into a no-op that reports the unchanged state.
module note_strike_tracker (
  input  logic            clk,
  input  logic            rst,
  nst_frame_if.sink       frame,
  nst_result_if.source    result,
  nst_cfg_if.sink         cfg
);

  nst_pkg::cfg_t    regs;
  nst_pkg::frame_t  frame_q;
  nst_pkg::result_t res_next;
  logic             frame_vld;
  logic             advance;

  nst_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  nst_tracker u_trk (
    .clk   (clk),
    .rst   (rst),
    .regs  (regs),
    .fire  (advance),
    .item  (frame_q),
    .res   (res_next)
  );

  assign advance     = frame_vld && (!result.valid || result.ready);
  assign frame.ready = !frame_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_vld <= 1'b0;
    end else if (frame.ready) begin
      frame_vld <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      frame_q <= frame.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.data <= res_next;
    end
  end

  a_mon_from_attack: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.data.tracker_state == nst_pkg::ST_MON &&
     result.data.previous_state != nst_pkg::ST_MON)
    |-> result.data.previous_state == nst_pkg::ST_ATTACK)
    else $error("monitoring entered from a state other than attack");

  a_wait_clean: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.data.tracker_state == nst_pkg::ST_WAIT)
    |-> (result.data.decline_count == '0 && !result.data.retrigger_ready))
    else $error("waiting state with live streak or armed retrigger");

  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> result.valid)
    else $error("frame advanced without producing a result");

endmodule
